[hdl/ssl_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted static list engine package
// Shared constants, command and status codes, sequencer states and the
// result record passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package ssl_pkg;

  // Default sizes of the slot array.
  localparam int DEF_CAPACITY     = 32;
  localparam int DEF_KEY_BITS     = 16;
  localparam int DEF_PAYLOAD_BITS = 16;

  // Fixed widths of the stream fields.
  localparam int KIND_W   = 3;
  localparam int KEY_W    = 16;
  localparam int PAY_W    = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;

  // Command codes.
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FIND   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST   = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_INS_WALK,
    S_INS_PLACE,
    S_INS_LINK,
    S_FIND_WALK,
    S_DEL_WALK,
    S_DEL_FREE,
    S_LIST,
    S_REPLY
  } state_t;

  // One result item offered to the output register.
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [PAY_W-1:0]    payload;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } res_t;

endpackage

[hdl/ssl_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ssl_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ssl_link_store.sv]
// ----------------------------------------------------------------------------
// Link store
// Holds the next-slot link of every slot. A slot that has not been written
// since reset or the last clear reads as its initial link (next slot, or
// null for the final slot), tracked by one valid bit per slot.
// ----------------------------------------------------------------------------
module ssl_link_store #(
  parameter int CAPACITY = 32,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int LINK_W   = IDX_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic [IDX_W-1:0]  raddr,
  output logic [LINK_W-1:0] rdata,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [LINK_W-1:0] wdata
);

  logic [CAPACITY-1:0] written;
  logic                rd_written;
  logic [IDX_W-1:0]    rd_addr;
  logic [LINK_W-1:0]   ram_q;
  logic [LINK_W-1:0]   succ;
  logic [LINK_W-1:0]   init_link;

  ssl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Written flags, all dropped at once by reset or a clear command.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  // Flag and address travel alongside the registered read data.
  always_ff @(posedge clk) begin
    rd_written <= written[raddr];
    rd_addr    <= raddr;
  end

  // Initial link of the slot that was read.
  assign succ      = LINK_W'(rd_addr) + LINK_W'(1);
  assign init_link = (succ < LINK_W'(CAPACITY)) ? succ : '1;
  assign rdata     = rd_written ? ram_q : init_link;

endmodule

[hdl/ssl_ctrl.sv]
// ----------------------------------------------------------------------------
// List sequencer
// Walks the sorted list one slot per cycle through the slot memories (in a
// list-all only while results can be taken), using one shared key
// comparator, and updates links and list heads per command.
module ssl_ctrl #(
  parameter int CAPACITY     = 32,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 16,
  parameter int IDX_W        = $clog2(CAPACITY),
  parameter int LINK_W       = IDX_W + 1,
  parameter int ENT_W        = KEY_BITS + PAYLOAD_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  // Command side
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ssl_pkg::KIND_W-1:0] in_kind,
  input  logic [ssl_pkg::KEY_W-1:0]  in_key,
  input  logic [ssl_pkg::PAY_W-1:0]  in_payload,
  input  logic                    reject_dup,
  // Result side
  input  logic                    can_emit,
  output ssl_pkg::res_t           res,
  // Slot memories
  output logic [IDX_W-1:0]        rd_addr,
  input  logic [ENT_W-1:0]        ent_rdata,
  output logic                    ent_we,
  output logic [IDX_W-1:0]        ent_waddr,
  output logic [ENT_W-1:0]        ent_wdata,
  input  logic [LINK_W-1:0]       lnk_rdata,
  output logic                    lnk_we,
  output logic [IDX_W-1:0]        lnk_waddr,
  output logic [LINK_W-1:0]       lnk_wdata,
  output logic                    lnk_clear
);

  import ssl_pkg::*;

  localparam logic [LINK_W-1:0] NIL = '1;

  state_t state, state_next;

  logic [KIND_W-1:0]       kind;
  logic [KEY_BITS-1:0]     key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [LINK_W-1:0]       cur;
  logic [LINK_W-1:0]       prev;
  logic [LINK_W-1:0]       list_head;
  logic [LINK_W-1:0]       free_head;

  logic [STATUS_W-1:0]     res_status;
  logic [KEY_W-1:0]        res_key;
  logic [PAY_W-1:0]        res_pay;
  logic [SLOT_W-1:0]       res_slot;

  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic                    k_gt;
  logic                    k_eq;
  logic                    link_nil;
  logic                    prev_nil;
  logic                    list_nil;
  logic                    free_nil;

  logic [63:0] in_key_wide, in_pay_wide;
  logic [63:0] key_q_wide, pay_q_wide, key_r_wide, pay_r_wide;
  logic [63:0] cur_wide, free_wide;
  logic [KEY_BITS-1:0]     in_key_k;
  logic [PAYLOAD_BITS-1:0] in_pay_p;

  // Field width adaptation.
  assign in_key_wide = 64'(in_key);
  assign in_pay_wide = 64'(in_payload);
  assign in_key_k    = in_key_wide[KEY_BITS-1:0];
  assign in_pay_p    = in_pay_wide[PAYLOAD_BITS-1:0];

  assign key_q      = ent_rdata[ENT_W-1 -: KEY_BITS];
  assign pay_q      = ent_rdata[PAYLOAD_BITS-1:0];
  assign key_q_wide = 64'(key_q);
  assign pay_q_wide = 64'(pay_q);
  assign key_r_wide = 64'(key_r);
  assign pay_r_wide = 64'(pay_r);
  assign cur_wide   = 64'(cur);
  assign free_wide  = 64'(free_head);

  // Shared key comparator and null tests; null links have the top bit set.
  assign k_gt     = key_r > key_q;
  assign k_eq     = key_r == key_q;
  assign link_nil = lnk_rdata[LINK_W-1];
  assign prev_nil = prev[LINK_W-1];
  assign list_nil = list_head[LINK_W-1];
  assign free_nil = free_head[LINK_W-1];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CMD;
      end
      S_CMD: begin
        unique case (kind)
          KIND_CLEAR:  state_next = S_REPLY;
          KIND_INSERT: begin
            if (free_nil)      state_next = S_REPLY;
            else if (list_nil) state_next = S_INS_PLACE;
            else               state_next = S_INS_WALK;
          end
          KIND_FIND:   state_next = list_nil ? S_REPLY : S_FIND_WALK;
          KIND_DELETE: state_next = list_nil ? S_REPLY : S_DEL_WALK;
          KIND_LIST:   state_next = list_nil ? S_REPLY : S_LIST;
          default:     state_next = S_IDLE;
        endcase
      end
      S_INS_WALK: begin
        priority if (k_gt) begin
          if (link_nil) state_next = S_INS_PLACE;
        end else if (reject_dup && k_eq) begin
          state_next = S_REPLY;
        end else begin
          state_next = S_INS_PLACE;
        end
      end
      S_INS_PLACE: state_next = S_INS_LINK;
      S_INS_LINK:  state_next = S_REPLY;
      S_FIND_WALK: begin
        if (k_eq || link_nil) state_next = S_REPLY;
      end
      S_DEL_WALK: begin
        priority if (k_gt) begin
          if (link_nil) state_next = S_REPLY;
        end else if (k_eq) begin
          state_next = S_DEL_FREE;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_DEL_FREE: state_next = S_REPLY;
      S_LIST: begin
        if (can_emit && link_nil) state_next = S_IDLE;
      end
      S_REPLY: begin
        if (can_emit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls and result offer.
  always_comb begin
    in_ready    = (state == S_IDLE);
    rd_addr     = cur[IDX_W-1:0];
    ent_we      = 1'b0;
    ent_waddr   = free_head[IDX_W-1:0];
    ent_wdata   = {key_r, pay_r};
    lnk_we      = 1'b0;
    lnk_waddr   = prev[IDX_W-1:0];
    lnk_wdata   = free_head;
    lnk_clear   = 1'b0;
    res.valid   = 1'b0;
    res.status  = res_status;
    res.key     = res_key;
    res.payload = res_pay;
    res.slot    = res_slot;
    res.last    = 1'b1;
    unique case (state)
      S_CMD: begin
        rd_addr = list_head[IDX_W-1:0];
        if (kind == KIND_CLEAR) lnk_clear = 1'b1;
      end
      S_INS_WALK: begin
        if (k_gt && !link_nil) rd_addr = lnk_rdata[IDX_W-1:0];
      end
      S_INS_PLACE: begin
        // Fetch the free slot's link while the new entry is written.
        rd_addr = free_head[IDX_W-1:0];
        ent_we  = 1'b1;
        lnk_we  = !prev_nil;
      end
      S_INS_LINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = free_head[IDX_W-1:0];
        lnk_wdata = cur;
      end
      S_FIND_WALK: begin
        if (!k_eq && !link_nil) rd_addr = lnk_rdata[IDX_W-1:0];
      end
      S_DEL_WALK: begin
        if (k_gt && !link_nil) begin
          rd_addr = lnk_rdata[IDX_W-1:0];
        end else if (!k_gt && k_eq && !prev_nil) begin
          lnk_we    = 1'b1;
          lnk_wdata = lnk_rdata;
        end
      end
      S_DEL_FREE: begin
        lnk_we    = 1'b1;
        lnk_waddr = cur[IDX_W-1:0];
      end
      S_LIST: begin
        res.valid   = can_emit;
        res.status  = ST_OK;
        res.key     = key_q_wide[KEY_W-1:0];
        res.payload = pay_q_wide[PAY_W-1:0];
        res.slot    = cur_wide[SLOT_W-1:0];
        res.last    = link_nil;
        if (can_emit && !link_nil) rd_addr = lnk_rdata[IDX_W-1:0];
      end
      S_REPLY: begin
        res.valid = can_emit;
      end
      default: begin
      end
    endcase
  end

  // State and list heads.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      list_head <= NIL;
      free_head <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CMD: begin
          if (kind == KIND_CLEAR) begin
            list_head <= NIL;
            free_head <= '0;
          end
        end
        S_INS_PLACE: begin
          if (prev_nil) list_head <= free_head;
        end
        S_INS_LINK: begin
          free_head <= lnk_rdata;
        end
        S_DEL_WALK: begin
          if (!k_gt && k_eq && prev_nil) list_head <= lnk_rdata;
        end
        S_DEL_FREE: begin
          free_head <= cur;
        end
        default: begin
        end
      endcase
    end
  end

  // Walk pointers, command fields and the pending result.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind  <= in_kind;
          key_r <= in_key_k;
          pay_r <= in_pay_p;
        end
      end
      S_CMD: begin
        cur      <= list_head;
        prev     <= NIL;
        res_key  <= '0;
        res_pay  <= '0;
        res_slot <= '0;
        unique case (kind)
          KIND_CLEAR:  res_status <= ST_OK;
          KIND_INSERT: res_status <= ST_FULL;
          KIND_FIND:   res_status <= ST_NOT_FOUND;
          default:     res_status <= ST_EMPTY;
        endcase
      end
      S_INS_WALK: begin
        if (k_gt) begin
          prev <= cur;
          cur  <= lnk_rdata;
        end else begin
          res_status <= ST_DUPLICATE;
          res_key    <= key_q_wide[KEY_W-1:0];
          res_pay    <= pay_q_wide[PAY_W-1:0];
          res_slot   <= cur_wide[SLOT_W-1:0];
        end
      end
      S_INS_LINK: begin
        res_status <= ST_OK;
        res_key    <= key_r_wide[KEY_W-1:0];
        res_pay    <= pay_r_wide[PAY_W-1:0];
        res_slot   <= free_wide[SLOT_W-1:0];
      end
      S_FIND_WALK: begin
        if (k_eq) begin
          res_status <= ST_OK;
          res_key    <= key_q_wide[KEY_W-1:0];
          res_pay    <= pay_q_wide[PAY_W-1:0];
          res_slot   <= cur_wide[SLOT_W-1:0];
        end else if (link_nil) begin
          res_status <= ST_NOT_FOUND;
        end else begin
          cur <= lnk_rdata;
        end
      end
      S_DEL_WALK: begin
        if (k_gt) begin
          if (link_nil) begin
            res_status <= ST_NOT_FOUND;
          end else begin
            prev <= cur;
            cur  <= lnk_rdata;
          end
        end else if (k_eq) begin
          res_status <= ST_OK;
          res_key    <= key_q_wide[KEY_W-1:0];
          res_pay    <= pay_q_wide[PAY_W-1:0];
          res_slot   <= cur_wide[SLOT_W-1:0];
        end else begin
          res_status <= ST_NOT_FOUND;
        end
      end
      S_LIST: begin
        if (can_emit && !link_nil) cur <= lnk_rdata;
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/sorted_static_list_engine_top.sv]
// ----------------------------------------------------------------------------
// Sorted static list engine
// Keeps a fixed array of slots chained into an ascending key-sorted list and
// a free list, and serves clear, insert, find, delete and list-all commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel: kind in tuser, key and payload in
//   tdata. Results leave on the m_axis channel, one item per result, with
//   tlast set on the final result of a command. List-all gives one item per
//   stored entry in key order (one empty-status item on an empty list);
//   every other command gives exactly one item, and unknown kinds give none.
//   The user writes the reject_duplicates register on the cfg channel only
//   while the block is idle; the block itself leaves this unchecked.
// Timing:
//   One command is worked on at a time; s_axis_tready is high only between
//   commands. The sequencer visits one slot per cycle, in a list-all only
//   while the receiver keeps up, so a command keeps the block busy longer
//   the more slots it walks. A list-all streams one item per cycle while
//   the receiver keeps up.
// Reset and stall:
//   Reset empties the list and frees every slot at once. A stalled receiver
//   holds the output register, and the sequencer waits until it drains.
// ----------------------------------------------------------------------------
module sorted_static_list_engine_top #(
  parameter int CAPACITY     = ssl_pkg::DEF_CAPACITY,
  parameter int KEY_BITS     = ssl_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = ssl_pkg::DEF_PAYLOAD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // Command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key[15:0], payload[31:16]
  input  logic [2:0]  s_axis_tuser,   // kind[2:0]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // status[2:0], found_key[18:3],
                                      // found_payload[34:19], slot[39:35]
  output logic        m_axis_tlast,   // last result of a command
  // Configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data        // reject_duplicates
);

  import ssl_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int LINK_W = IDX_W + 1;
  localparam int ENT_W  = KEY_BITS + PAYLOAD_BITS;

  logic              reject_dup;
  logic              can_emit;
  res_t              res;
  logic [IDX_W-1:0]  rd_addr;
  logic [ENT_W-1:0]  ent_rdata;
  logic              ent_we;
  logic [IDX_W-1:0]  ent_waddr;
  logic [ENT_W-1:0]  ent_wdata;
  logic [LINK_W-1:0] lnk_rdata;
  logic              lnk_we;
  logic [IDX_W-1:0]  lnk_waddr;
  logic [LINK_W-1:0] lnk_wdata;
  logic              lnk_clear;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reject_dup <= 1'b0;
    end else if (cfg_valid) begin
      reject_dup <= cfg_data;
    end
  end

  // Key and payload of every slot.
  ssl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (rd_addr),
    .rdata (ent_rdata)
  );

  // Links of every slot.
  ssl_link_store #(
    .CAPACITY (CAPACITY)
  ) u_links (
    .clk   (clk),
    .rst   (rst),
    .clear (lnk_clear),
    .raddr (rd_addr),
    .rdata (lnk_rdata),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata)
  );

  // Command sequencer.
  ssl_ctrl #(
    .CAPACITY     (CAPACITY),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_kind    (s_axis_tuser),
    .in_key     (s_axis_tdata[15:0]),
    .in_payload (s_axis_tdata[31:16]),
    .reject_dup (reject_dup),
    .can_emit   (can_emit),
    .res        (res),
    .rd_addr    (rd_addr),
    .ent_rdata  (ent_rdata),
    .ent_we     (ent_we),
    .ent_waddr  (ent_waddr),
    .ent_wdata  (ent_wdata),
    .lnk_rdata  (lnk_rdata),
    .lnk_we     (lnk_we),
    .lnk_waddr  (lnk_waddr),
    .lnk_wdata  (lnk_wdata),
    .lnk_clear  (lnk_clear)
  );

  // Output register: loads a new item when empty or being drained.
  assign can_emit = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (can_emit) begin
      m_axis_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit && res.valid) begin
      m_axis_tdata <= {res.slot, res.payload, res.key, res.status};
      m_axis_tlast <= res.last;
    end
  end

endmodule

[tb/sorted_static_list_engine_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted static list engine checker
// Watches the command, result and configuration channels, keeps its own
// copy of the slot array, links and heads, predicts the result items of
// each accepted command and compares every accepted result with them.
// ----------------------------------------------------------------------------
module sorted_static_list_engine_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key[15:0], payload[31:16]
  input  logic [2:0]  s_axis_tuser,   // kind[2:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // status[2:0], found_key[18:3],
                                      // found_payload[34:19], slot[39:35]
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          err_count,
  output int          pending
);

  import ssl_pkg::*;

  localparam int         SLOTS      = DEF_CAPACITY;
  localparam logic [5:0] NO_SLOT    = 6'h3F;
  localparam int         REPORT_MAX = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [PAY_W-1:0]    payload;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } entry_result_t;

  // Shadow copy of the engine state.
  logic [KEY_W-1:0] key_mem  [SLOTS];
  logic [PAY_W-1:0] pay_mem  [SLOTS];
  logic [5:0]       link_mem [SLOTS];
  logic [5:0]       list_head;
  logic [5:0]       free_head;
  logic             dup_reject;

  entry_result_t    expected_q [$];
  int               mismatches;

  // Chain every slot into the free list and empty the sorted list.
  task automatic relink_all();
    for (int i = 0; i < SLOTS; i++) begin
      link_mem[i] = (i + 1 < SLOTS) ? 6'(i + 1) : NO_SLOT;
    end
    list_head = NO_SLOT;
    free_head = 6'd0;
  endtask

  // Queue one expected result; a missing slot gives zero fields.
  task automatic queue_result(input logic [STATUS_W-1:0] status, input logic [5:0] s,
                              input logic last);
    entry_result_t r;
    r.status = status;
    if (s < SLOTS) begin
      r.key     = key_mem[s];
      r.payload = pay_mem[s];
      r.slot    = s[SLOT_W-1:0];
    end else begin
      r.key     = '0;
      r.payload = '0;
      r.slot    = '0;
    end
    r.last = last;
    expected_q.push_back(r);
  endtask

  // Apply one command to the shadow state and queue its results.
  task automatic apply_command(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                               input logic [PAY_W-1:0] pay);
    logic [5:0] prev;
    logic [5:0] cur;
    logic [5:0] nw;
    logic [5:0] nx;
    int         steps;
    int         n;
    prev  = NO_SLOT;
    cur   = list_head;
    steps = 0;
    n     = 0;
    case (kind)
      KIND_CLEAR: begin
        relink_all();
        queue_result(ST_OK, NO_SLOT, 1'b1);
      end
      KIND_INSERT: begin
        if (free_head >= SLOTS) begin
          queue_result(ST_FULL, NO_SLOT, 1'b1);
        end else begin
          // Stop at the first entry whose key is equal or larger.
          while (cur < SLOTS && steps < SLOTS && key > key_mem[cur]) begin
            prev = cur;
            cur  = link_mem[cur];
            steps++;
          end
          if (cur >= SLOTS) cur = NO_SLOT;
          if (dup_reject && cur != NO_SLOT && key_mem[cur] == key) begin
            queue_result(ST_DUPLICATE, cur, 1'b1);
          end else begin
            nw            = free_head;
            free_head     = link_mem[nw];
            key_mem[nw]   = key;
            pay_mem[nw]   = pay;
            link_mem[nw]  = cur;
            if (prev == NO_SLOT) list_head = nw;
            else link_mem[prev] = nw;
            queue_result(ST_OK, nw, 1'b1);
          end
        end
      end
      KIND_FIND: begin
        while (cur < SLOTS && steps < SLOTS && key_mem[cur] != key) begin
          cur = link_mem[cur];
          steps++;
        end
        if (cur < SLOTS && key_mem[cur] == key) queue_result(ST_OK, cur, 1'b1);
        else queue_result(ST_NOT_FOUND, NO_SLOT, 1'b1);
      end
      KIND_DELETE: begin
        if (list_head >= SLOTS) begin
          queue_result(ST_EMPTY, NO_SLOT, 1'b1);
        end else begin
          while (cur < SLOTS && steps < SLOTS && key_mem[cur] < key) begin
            prev = cur;
            cur  = link_mem[cur];
            steps++;
          end
          if (cur < SLOTS && key_mem[cur] == key) begin
            // Unlink the entry and push its slot on the free list.
            if (prev == NO_SLOT) list_head = link_mem[cur];
            else link_mem[prev] = link_mem[cur];
            link_mem[cur] = free_head;
            free_head     = cur;
            queue_result(ST_OK, cur, 1'b1);
          end else begin
            queue_result(ST_NOT_FOUND, NO_SLOT, 1'b1);
          end
        end
      end
      KIND_LIST: begin
        if (cur >= SLOTS) begin
          queue_result(ST_EMPTY, NO_SLOT, 1'b1);
        end else begin
          while (cur < SLOTS && n < SLOTS) begin
            nx = link_mem[cur];
            queue_result(ST_OK, cur, (nx >= SLOTS || n + 1 >= SLOTS));
            n++;
            cur = nx;
          end
        end
      end
      default: begin
        // Spare kinds are dropped without a result.
      end
    endcase
  endtask

  // Follow the three channels at each rising edge.
  always @(posedge clk) begin
    entry_result_t got;
    entry_result_t exp_r;
    if (rst) begin
      relink_all();
      dup_reject = 1'b0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) dup_reject = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_command(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = m_axis_tdata[2:0];
        got.key     = m_axis_tdata[18:3];
        got.payload = m_axis_tdata[34:19];
        got.slot    = m_axis_tdata[39:35];
        got.last    = m_axis_tlast;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: unexpected result status=%0d key=%h payload=%h slot=%0d last=%b",
                     $realtime, got.status, got.key, got.payload, got.slot, got.last);
          end
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: mismatch expected status=%0d key=%h payload=%h slot=%0d last=%b",
                       $realtime, exp_r.status, exp_r.key, exp_r.payload, exp_r.slot,
                       exp_r.last);
              $display("%0t: mismatch actual   status=%0d key=%h payload=%h slot=%0d last=%b",
                       $realtime, got.status, got.key, got.payload, got.slot, got.last);
            end
          end
        end
      end
    end
    pending   <= expected_q.size();
    err_count <= mismatches;
  end

endmodule

[tb/sorted_static_list_engine_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted static list engine testbench
// Drives commands and reject_duplicates writes into the engine, with random
// idle bursts on the command and result channels, and leaves prediction and
// comparison to the checker. Directed commands cover the empty, duplicate and
// spare-kind cases; random phases fill, search, thin and list the array.
// ----------------------------------------------------------------------------
module sorted_static_list_engine_top_tb;
  import ssl_pkg::*;

  localparam int              CYCLE_LIMIT   = 400000;
  localparam int              IDLE_TAIL     = 50;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  int          err_count;
  int          pending;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;

  always #5 clk = ~clk;

  sorted_static_list_engine_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  sorted_static_list_engine_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .err_count     (err_count),
    .pending       (pending)
  );

  // Result receiver with random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(1, 6) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_static_list_engine_top_tb: errors");
      $finish;
    end
  end

  // Offer one command item, optionally after an idle burst.
  task automatic send_command(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                              input logic [PAY_W-1:0] pay);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pay, key};
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Hold off commands until every expected result item has come.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // Write reject_duplicates; the engine is idle here.
  task automatic write_reject(input logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Keys mostly from a small pool so that finds, deletes and duplicates hit.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0, 1:    pick_key = KEY_W'($urandom_range(0, 15));
      2:       pick_key = 16'hFFF0 | KEY_W'($urandom_range(0, 15));
      default: pick_key = KEY_W'($urandom);
    endcase
  endfunction

  // Random commands with weights in percent; spare kinds do not count.
  task automatic random_phase(input int count, input int w_ins, input int w_find,
                              input int w_del);
    int done;
    int r;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_command(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), KEY_W'($urandom),
                     PAY_W'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) send_command(KIND_CLEAR, KEY_W'($urandom), PAY_W'($urandom));
        else if (r < 3 + w_ins) send_command(KIND_INSERT, pick_key(), PAY_W'($urandom));
        else if (r < 3 + w_ins + w_find) send_command(KIND_FIND, pick_key(), PAY_W'($urandom));
        else if (r < 3 + w_ins + w_find + w_del)
          send_command(KIND_DELETE, pick_key(), PAY_W'($urandom));
        else send_command(KIND_LIST, KEY_W'($urandom), PAY_W'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list, then the key and payload extremes with a kept duplicate.
    send_command(KIND_LIST, 16'h0000, 16'h0000);
    send_command(KIND_DELETE, 16'h0001, 16'h0000);
    send_command(KIND_FIND, 16'h0000, 16'h0000);
    send_command(KIND_INSERT, 16'h0000, 16'hFFFF);
    send_command(KIND_INSERT, 16'hFFFF, 16'h0000);
    send_command(KIND_INSERT, 16'h8000, 16'h1234);
    send_command(KIND_INSERT, 16'h8000, 16'hA5A5);
    send_command(KIND_FIND, 16'hFFFF, 16'hFFFF);
    send_command(KIND_FIND, 16'h8000, 16'h0000);
    send_command(KIND_FIND, 16'h7FFF, 16'h0000);
    send_command(KIND_LIST, 16'hFFFF, 16'hFFFF);
    send_command(KIND_DELETE, 16'h8000, 16'h0000);
    send_command(KIND_DELETE, 16'h4321, 16'h0000);
    send_command(KIND_DELETE, 16'h0000, 16'h0000);
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) begin
      send_command(KIND_W'(k), KEY_W'($urandom), PAY_W'($urandom));
    end
    send_command(KIND_LIST, 16'h0000, 16'h0000);
    send_command(KIND_CLEAR, 16'hFFFF, 16'hFFFF);
    send_command(KIND_LIST, 16'h0000, 16'h0000);

    // Duplicate refused once the register is set.
    wait_drained();
    write_reject(1'b1);
    send_command(KIND_INSERT, 16'h0042, 16'h5A5A);
    send_command(KIND_INSERT, 16'h0042, 16'h0F0F);
    send_command(KIND_FIND, 16'h0042, 16'h0000);
    send_command(KIND_LIST, 16'h0000, 16'h0000);

    // Random phases over several register settings.
    wait_drained();
    write_reject(1'b0);
    random_phase(40, 45, 20, 20);
    wait_drained();
    write_reject(1'b1);
    random_phase(40, 75, 8, 7);
    wait_drained();
    write_reject(1'b0);
    random_phase(35, 30, 15, 40);
    wait_drained();
    write_reject(1'b1);
    idle_on = 1'b0;
    random_phase(25, 40, 20, 20);

    wait_drained();
    if (err_count == 0) begin
      $display("sorted_static_list_engine_top_tb: clean");
    end else begin
      $display("sorted_static_list_engine_top_tb: errors");
    end
    $finish;
  end

endmodule
